@@ rtl/core/cdar_pkg.sv @@
// Package for the conditional drawdown at risk block: types, sizes and codes.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package cdar_pkg;

    localparam int TOP_DEPTH  = 256;
    localparam int VAL_W      = 32;
    localparam int TAIL_W     = 9;
    localparam int PATHS_W    = 17;
    localparam int SUM_W      = 48;
    localparam int DIVISOR_W  = 17;
    localparam int IDX_W      = $clog2(TOP_DEPTH);
    localparam logic [PATHS_W-1:0] MAX_PATHS = PATHS_W'(65536);
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TAIL_W-1:0]  TAIL_RESET = TAIL_W'(1);
    localparam logic [1:0]         ADDR_TAIL_COUNT = 2'd0;

    // One classified sample handed from the front to the back
    typedef struct packed {
        logic             first;      // first sample of a path: clear the list
        logic             dd_valid;   // sample lies below the peak
        logic [VAL_W-1:0] drawdown;
        logic             end_path;
        logic             end_batch;
    } cdar_item_t;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } cdar_div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PLACE,
        ST_SUM,
        ST_DIV_PATH,
        ST_BATCH,
        ST_DIV_BATCH,
        ST_OUT
    } cdar_state_t;

endpackage

@@ rtl/core/conditional_drawdown_at_risk.sv @@
// Conditional drawdown at risk over a batch of paths. The back end inserts each
// drawdown into a sorted list, walking past every smaller held entry; a path end
// adds summation of the largest min(tail_count, drawdowns held) entries (a zero
// tail_count is taken as 1) and a division, and the batch end one more division
// before the result is registered. The 2-entry queue lets the front run ahead.
// Reset (rst_n, asynchronous) clears all path and batch state; tail_count = 1.
`timescale 1ns / 1ps
module conditional_drawdown_at_risk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_value
    input  logic        s_tlast,   // last_in_path
    input  logic        s_tuser,   // [0] last_in_batch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [31:0] cdar_average, [48:32] paths_counted
);
    import cdar_pkg::*;

    logic [TAIL_W-1:0]  tail_reg, tail_next;
    logic               fq_valid, fq_ready, bq_valid, bq_ready;
    cdar_item_t         fq_item, bq_item;
    logic [VAL_W-1:0]   avg;
    logic [PATHS_W-1:0] paths;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TAIL_COUNT) ? 32'(tail_reg) : 32'd0;
    assign m_tdata = {7'd0, paths, avg};

    always_comb
    begin
        tail_next = tail_reg;
        if (psel && penable && pwrite)
            tail_next = pwdata[TAIL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_reg <= TAIL_RESET;
        else
            tail_reg <= tail_next;
    end

    cdar_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_value      (s_tdata),
        .in_last_path  (s_tlast),
        .in_last_batch (s_tuser),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    cdar_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_item  (bq_item)
    );

    cdar_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tail_count  (tail_reg),
        .q_valid     (bq_valid),
        .q_ready     (bq_ready),
        .q_item      (bq_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_average (avg),
        .out_paths   (paths)
    );

endmodule

@@ rtl/core/cdar_front.sv @@
// Front end: takes samples, tracks the running peak and classifies drawdowns.
// Depends on cdar_pkg.
`timescale 1ns / 1ps
module cdar_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [cdar_pkg::VAL_W-1:0] in_value,
    input  logic                     in_last_path,
    input  logic                     in_last_batch,
    output logic                     q_valid,
    input  logic                     q_ready,
    output cdar_pkg::cdar_item_t     q_item
);
    import cdar_pkg::*;

    logic signed [VAL_W-1:0] peak_reg, peak_next;
    logic                    started_reg, started_next;
    logic signed [VAL_W-1:0] peak_eff;
    logic signed [VAL_W-1:0] value_s;
    logic                    accept;

    assign value_s  = $signed(in_value);
    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid && q_ready;
    assign peak_eff = started_reg ? peak_reg : value_s;

    always_comb
    begin
        q_item.first     = !started_reg;
        q_item.dd_valid  = value_s < peak_eff;
        q_item.drawdown  = VAL_W'(peak_eff - value_s);
        q_item.end_path  = in_last_path || in_last_batch;
        q_item.end_batch = in_last_batch;
        peak_next    = peak_reg;
        started_next = started_reg;
        if (accept)
        begin
            peak_next    = (value_s >= peak_eff) ? value_s : peak_eff;
            started_next = !(in_last_path || in_last_batch);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            peak_reg    <= peak_next;
            started_reg <= started_next;
        end
    end

endmodule

@@ rtl/core/cdar_fifo.sv @@
// Two-entry queue between the front and the back end.
// Depends on cdar_pkg.
`timescale 1ns / 1ps
module cdar_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  cdar_pkg::cdar_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output cdar_pkg::cdar_item_t rd_item
);
    import cdar_pkg::*;

    cdar_item_t mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/cdar_div.sv @@
// Restoring divider, one quotient bit a cycle, shared by both divisions.
// Depends on cdar_pkg.
`timescale 1ns / 1ps
module cdar_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdar_pkg::cdar_div_req_t       req,
    output logic                          done,
    output logic [cdar_pkg::SUM_W-1:0]    quotient
);
    import cdar_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_W])
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

@@ rtl/core/cdar_back.sv @@
// Back end: sorted drawdown list, tail summation, per-path and batch averages.
// Depends on cdar_pkg and cdar_div.
`timescale 1ns / 1ps
module cdar_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cdar_pkg::TAIL_W-1:0]   tail_count,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  cdar_pkg::cdar_item_t          q_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cdar_pkg::VAL_W-1:0]    out_average,
    output logic [cdar_pkg::PATHS_W-1:0]  out_paths
);
    import cdar_pkg::*;

    localparam int LSUM_W = VAL_W + IDX_W;
    localparam int FILL_W = IDX_W + 1;

    cdar_state_t          state_reg, state_next;
    logic [VAL_W-1:0]     list_mem [TOP_DEPTH];
    logic [VAL_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [VAL_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    fill_eff;
    logic [TAIL_W-1:0]    sum_n;
    logic [VAL_W-1:0]     dd_reg, dd_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 end_reg, end_next;
    logic                 rdv_reg, rdv_next;
    logic [TAIL_W-1:0]    k_reg, k_next;
    logic [TAIL_W-1:0]    t_eff;
    logic [LSUM_W-1:0]    lsum_reg, lsum_next;
    logic [LSUM_W-1:0]    lsum_add;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [PATHS_W-1:0]   paths_reg, paths_next;
    logic                 batch_reg, batch_next;
    logic                 ovalid_reg, ovalid_next;
    logic [VAL_W-1:0]     oavg_reg, oavg_next;
    logic [PATHS_W-1:0]   opaths_reg, opaths_next;
    logic [SUM_W:0]       acc_add;
    cdar_div_req_t        div_req;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quo;

    cdar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid   = ovalid_reg;
    assign out_average = oavg_reg;
    assign out_paths   = opaths_reg;
    assign q_ready     = state_reg == ST_IDLE;

    always_comb
    begin
        if (tail_count == '0)
            t_eff = TAIL_W'(1);
        else if (tail_count > TAIL_W'(TOP_DEPTH))
            t_eff = TAIL_W'(TOP_DEPTH);
        else
            t_eff = tail_count;
    end

    always_comb
    begin
        fill_eff    = q_item.first ? '0 : fill_reg;
        sum_n       = (t_eff < fill_reg) ? t_eff : fill_reg;
        lsum_add    = lsum_reg + (rdv_reg ? LSUM_W'(rd_data_reg) : '0);
        acc_add     = {1'b0, acc_reg} + {1'b0, div_quo};
        state_next  = state_reg;
        fill_next   = fill_reg;
        dd_next     = dd_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        k_next      = '0;
        lsum_next   = '0;
        rdv_next    = 1'b0;
        acc_next    = acc_reg;
        paths_next  = paths_reg;
        batch_next  = batch_reg;
        ovalid_next = ovalid_reg;
        oavg_next   = oavg_reg;
        opaths_next = opaths_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = dd_reg;
        mem_raddr   = '0;
        div_req.start    = 1'b0;
        div_req.dividend = SUM_W'(lsum_reg);
        div_req.divisor  = DIVISOR_W'(t_eff);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    fill_next  = fill_eff;
                    dd_next    = q_item.drawdown;
                    end_next   = q_item.end_path;
                    batch_next = q_item.end_batch;
                    if (q_item.dd_valid)
                    begin
                        fill_next = (fill_eff == FILL_W'(TOP_DEPTH)) ? fill_eff
                                                                    : fill_eff + 1'b1;
                        if (fill_eff == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = q_item.drawdown;
                            if (q_item.end_path)
                                state_next = ST_SUM;
                        end
                        else
                        begin
                            // Walk up from the smallest held entry
                            mem_raddr  = IDX_W'(fill_eff - 1'b1);
                            pos_next   = IDX_W'(fill_eff - 1'b1);
                            state_next = ST_INSERT;
                        end
                    end
                    else if (q_item.end_path)
                        state_next = ST_SUM;
                end
            end
            ST_INSERT:
            begin
                // rd_data_reg holds the entry at pos_reg; fetch the one above
                mem_raddr = pos_reg - 1'b1;
                mem_waddr = pos_reg + 1'b1;
                mem_we    = pos_reg != IDX_W'(TOP_DEPTH - 1);
                if (rd_data_reg < dd_reg)
                begin
                    // Move the smaller entry one place down; drop it off the end
                    mem_wdata = rd_data_reg;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == '0)
                        state_next = ST_PLACE;
                end
                else
                begin
                    mem_wdata  = dd_reg;
                    state_next = end_reg ? ST_SUM : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = dd_reg;
                state_next = end_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                // Entries beyond the fill count are skipped
                if (k_reg != sum_n)
                begin
                    mem_raddr = IDX_W'(k_reg);
                    k_next    = k_reg + 1'b1;
                    lsum_next = lsum_add;
                    rdv_next  = 1'b1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = SUM_W'(lsum_add);
                    state_next       = ST_DIV_PATH;
                end
            end
            ST_DIV_PATH:
            begin
                if (div_done)
                begin
                    if (paths_reg < MAX_PATHS)
                    begin
                        acc_next   = acc_add[SUM_W] ? SUM_MAX : acc_add[SUM_W-1:0];
                        paths_next = paths_reg + 1'b1;
                    end
                    state_next = batch_reg ? ST_BATCH : ST_IDLE;
                end
            end
            ST_BATCH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg;
                div_req.divisor  = DIVISOR_W'(paths_reg);
                state_next       = ST_DIV_BATCH;
            end
            ST_DIV_BATCH:
            begin
                if (div_done && !ovalid_reg)
                begin
                    if (paths_reg == '0)
                        oavg_next = '0;
                    else if (div_quo[SUM_W-1:VAL_W] != '0)
                        oavg_next = {VAL_W{1'b1}};
                    else
                        oavg_next = div_quo[VAL_W-1:0];
                    opaths_next = paths_reg;
                    ovalid_next = 1'b1;
                    acc_next    = '0;
                    paths_next  = '0;
                    state_next  = ST_IDLE;
                end
                else if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Quotient held in the divider; wait for the output register
                if (!ovalid_reg)
                begin
                    if (paths_reg == '0)
                        oavg_next = '0;
                    else if (div_quo[SUM_W-1:VAL_W] != '0)
                        oavg_next = {VAL_W{1'b1}};
                    else
                        oavg_next = div_quo[VAL_W-1:0];
                    opaths_next = paths_reg;
                    ovalid_next = 1'b1;
                    acc_next    = '0;
                    paths_next  = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // A new result is only loaded while the register is empty
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            list_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= list_mem[mem_raddr];
        lsum_reg    <= lsum_next;
        dd_reg      <= dd_next;
        pos_reg     <= pos_next;
        oavg_reg    <= oavg_next;
        opaths_reg  <= opaths_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            end_reg    <= 1'b0;
            rdv_reg    <= 1'b0;
            k_reg      <= '0;
            acc_reg    <= '0;
            paths_reg  <= '0;
            batch_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            end_reg    <= end_next;
            rdv_reg    <= rdv_next;
            k_reg      <= k_next;
            acc_reg    <= acc_next;
            paths_reg  <= paths_next;
            batch_reg  <= batch_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
